[rtl/core/mfq_pkg.sv]
// Shared types and constants for the multilevel feedback queue scheduler.
`default_nettype none
package mfq_pkg;

  // Item opcodes.
  localparam logic [2:0] OP_SET      = 3'd0;
  localparam logic [2:0] OP_INIT     = 3'd1;
  localparam logic [2:0] OP_PICK     = 3'd2;
  localparam logic [2:0] OP_TICK     = 3'd3;
  localparam logic [2:0] OP_BURST    = 3'd4;
  localparam logic [2:0] OP_PERIODIC = 3'd5;
  localparam logic [2:0] OP_ACTIVATE = 3'd6;

  // Slot run states.
  localparam logic [2:0] ST_UNUSED   = 3'd0;
  localparam logic [2:0] ST_RUNNABLE = 3'd1;
  localparam logic [2:0] ST_SLEEPING = 3'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_BOOST  = 3'd0;
  localparam logic [2:0] REG_ALLOT0 = 3'd1;
  localparam logic [2:0] REG_ALLOT3 = 3'd4;

  localparam logic [15:0] USED_MAX = 16'hFFFF;
  localparam logic [31:0] BOOST_RESET = 32'd100;
  localparam logic [3:0][15:0] ALLOT_RESET = {16'd8, 16'd4, 16'd2, 16'd1};

  // One slot table entry.
  typedef struct packed {
    logic [2:0]  run_state;
    logic        kernel;
    logic [1:0]  prio;
    logic [15:0] used;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

[rtl/core/mfq_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module mfq_ram #(
  parameter int WIDTH = 22,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/core/mfq_alu.sv]
// Shared slot update unit: computes the new entry, the hit flag and the pick match.
`default_nettype none
module mfq_alu #(
  parameter int LEVEL_COUNT = 4
) (
  input  wire logic [2:0]       op,
  input  wire mfq_pkg::entry_t  ent_in,
  input  wire logic [2:0]       new_state,
  input  wire logic             new_kernel,
  input  wire logic [1:0]       level,
  input  wire logic [3:0][15:0] allot,
  output mfq_pkg::entry_t       ent_out,
  output logic                  hit,
  output logic                  match
);

  localparam logic [1:0] LAST_LEVEL = 2'(LEVEL_COUNT - 1);

  logic [15:0] used_inc;
  logic [1:0]  eff_level;

  assign used_inc  = (ent_in.used == mfq_pkg::USED_MAX) ? ent_in.used : ent_in.used + 16'd1;
  assign eff_level = ent_in.kernel ? LAST_LEVEL : ent_in.prio;
  assign match     = (ent_in.run_state == mfq_pkg::ST_RUNNABLE) && (eff_level == level);

  // Per-opcode entry update.
  always_comb begin
    ent_out = ent_in;
    hit     = 1'b0;
    case (op)
      mfq_pkg::OP_SET: begin
        ent_out.run_state = new_state;
        ent_out.kernel    = new_kernel;
      end
      mfq_pkg::OP_INIT: begin
        ent_out.run_state = new_state;
        ent_out.kernel    = new_kernel;
        ent_out.prio      = 2'd0;
        ent_out.used      = 16'd0;
      end
      mfq_pkg::OP_TICK: begin
        ent_out.used = used_inc;
        hit          = used_inc >= allot[ent_in.prio];
      end
      mfq_pkg::OP_BURST: begin
        if (ent_in.run_state == mfq_pkg::ST_RUNNABLE) begin
          if (ent_in.prio < LAST_LEVEL) begin
            ent_out.prio = ent_in.prio + 2'd1;
          end
          ent_out.used = 16'd0;
        end else if (ent_in.run_state == mfq_pkg::ST_SLEEPING) begin
          ent_out.used = 16'd0;
        end
      end
      mfq_pkg::OP_PERIODIC, mfq_pkg::OP_ACTIVATE: begin
        if (ent_in.run_state != mfq_pkg::ST_UNUSED) begin
          ent_out.prio = 2'd0;
          ent_out.used = 16'd0;
        end
      end
      default: begin
        ent_out = ent_in;
      end
    endcase
  end

endmodule
`default_nettype wire

[rtl/core/multilevel_feedback_queue_scheduler_core.sv]
// Multilevel feedback queue scheduler: top level with sequencer, slot table and registers.
// Set, init, run tick and burst end go from accept to result through read, update and output.
// Pick reads one slot at a time (read, then evaluate), from each level's cursor, up to SLOT_COUNT slots per level.
// Periodic with boost and activate sweep the whole table, one slot after another.
// One item at a time; the next item is accepted when the result has been loaded out.
// Reset clears control state, registers to defaults and the per-slot valid bits.
`default_nettype none
module multilevel_feedback_queue_scheduler_core #(
  parameter int SLOT_COUNT  = 64,
  parameter int LEVEL_COUNT = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [2:0]  s_tuser,   // opcode
  input  wire logic [79:0] s_tdata,   // slot_index[5:0], slot_state[8:6], kernel_thread[9], now[73:10]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // hit[0], chosen_slot[6:1]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int SW = $clog2(SLOT_COUNT);
  localparam int LW = $clog2(LEVEL_COUNT);
  localparam logic [SW-1:0] LAST_SLOT = SW'(SLOT_COUNT - 1);
  localparam logic [LW-1:0] LAST_LV   = LW'(LEVEL_COUNT - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_EV   = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]       state;
  logic [2:0]       op_q;
  logic [2:0]       st_q;
  logic             kt_q;
  logic [SW-1:0]    idx;
  logic [SW-1:0]    cnt;
  logic [LW-1:0]    lv;
  logic [SW-1:0]    cursor [LEVEL_COUNT];
  logic [63:0]      last_boost;
  logic [31:0]      boost_int;
  logic [3:0][15:0] allot;
  logic [SLOT_COUNT-1:0] valid;
  logic             hit_q;
  logic [5:0]       chosen_q;

  logic [5:0]  in_slot;
  logic [2:0]  in_state;
  logic        in_kt;
  logic [63:0] in_now;
  logic        slot_ok;
  logic        boost_due;
  logic [SW-1:0] idx_inc;

  logic [mfq_pkg::ENTRY_W-1:0] ram_rdata;
  mfq_pkg::entry_t ent_rd;
  mfq_pkg::entry_t ent_wr;
  logic            alu_hit;
  logic            alu_match;
  logic            ram_we;

  assign in_slot  = s_tdata[5:0];
  assign in_state = s_tdata[8:6];
  assign in_kt    = s_tdata[9];
  assign in_now   = s_tdata[73:10];
  assign slot_ok  = {3'b000, in_slot} < 9'(SLOT_COUNT);
  assign boost_due = (in_now - last_boost) >= {32'd0, boost_int};
  assign idx_inc  = (idx == LAST_SLOT) ? '0 : idx + 1'b1;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // Slot table and its update unit; never-written entries read as unused.
  mfq_ram #(.WIDTH(mfq_pkg::ENTRY_W), .DEPTH(SLOT_COUNT)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx),
    .wdata (ent_wr),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  assign ent_rd = valid[idx] ? mfq_pkg::entry_t'(ram_rdata) : '0;
  assign ram_we = (state == S_EV) && (op_q != mfq_pkg::OP_PICK);

  mfq_alu #(.LEVEL_COUNT(LEVEL_COUNT)) u_alu (
    .op         (op_q),
    .ent_in     (ent_rd),
    .new_state  (st_q),
    .new_kernel (kt_q),
    .level      (2'(lv)),
    .allot      (allot),
    .ent_out    (ent_wr),
    .hit        (alu_hit),
    .match      (alu_match)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      boost_int <= mfq_pkg::BOOST_RESET;
      allot     <= mfq_pkg::ALLOT_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == mfq_pkg::REG_BOOST) begin
        boost_int <= cfg_data;
      end else if (cfg_index >= mfq_pkg::REG_ALLOT0 && cfg_index <= mfq_pkg::REG_ALLOT3) begin
        allot[2'(cfg_index - mfq_pkg::REG_ALLOT0)] <= cfg_data[15:0];
      end
    end
  end

  // Valid bits for the slot table.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (ram_we) begin
      valid[idx] <= 1'b1;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      m_tvalid   <= 1'b0;
      last_boost <= 64'd0;
      for (int i = 0; i < LEVEL_COUNT; i++) begin
        cursor[i] <= '0;
      end
    end else begin
      // The output register empties when taken, unless a new result is loaded.
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op_q     <= s_tuser;
            st_q     <= in_state;
            kt_q     <= in_kt;
            hit_q    <= (s_tuser == mfq_pkg::OP_PERIODIC) && boost_due;
            chosen_q <= 6'd0;
            lv       <= '0;
            cnt      <= '0;
            case (s_tuser)
              mfq_pkg::OP_SET, mfq_pkg::OP_INIT, mfq_pkg::OP_TICK, mfq_pkg::OP_BURST: begin
                idx <= SW'(in_slot);
                if (slot_ok) begin
                  state <= S_RD;
                end else begin
                  state <= S_DONE;
                end
              end
              mfq_pkg::OP_PICK: begin
                idx   <= cursor[0];
                state <= S_RD;
              end
              mfq_pkg::OP_PERIODIC: begin
                idx <= '0;
                if (boost_due) begin
                  last_boost <= in_now;
                  state      <= S_RD;
                end else begin
                  state <= S_DONE;
                end
              end
              mfq_pkg::OP_ACTIVATE: begin
                idx        <= '0;
                last_boost <= in_now;
                for (int i = 0; i < LEVEL_COUNT; i++) begin
                  cursor[i] <= '0;
                end
                state <= S_RD;
              end
              default: begin
                idx   <= '0;
                state <= S_DONE;
              end
            endcase
          end
        end
        S_RD: begin
          state <= S_EV;
        end
        S_EV: begin
          case (op_q)
            mfq_pkg::OP_PICK: begin
              if (alu_match) begin
                cursor[lv] <= idx_inc;
                hit_q      <= 1'b1;
                chosen_q   <= 6'(idx);
                state      <= S_DONE;
              end else if (cnt == LAST_SLOT) begin
                if (lv == LAST_LV) begin
                  state <= S_DONE;
                end else begin
                  lv    <= lv + 1'b1;
                  idx   <= cursor[lv + 1'b1];
                  cnt   <= '0;
                  state <= S_RD;
                end
              end else begin
                idx   <= idx_inc;
                cnt   <= cnt + 1'b1;
                state <= S_RD;
              end
            end
            mfq_pkg::OP_PERIODIC, mfq_pkg::OP_ACTIVATE: begin
              if (idx == LAST_SLOT) begin
                state <= S_DONE;
              end else begin
                idx   <= idx + 1'b1;
                state <= S_RD;
              end
            end
            default: begin
              hit_q <= alu_hit;
              state <= S_DONE;
            end
          endcase
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {1'b0, chosen_q, hit_q};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The block takes no second request while one is in progress.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while busy");

  // A nonzero chosen slot only comes with a hit.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[6:1] == 6'd0)
    else $error("chosen slot without hit");

  // A table write only happens in the update step.
  assert property (@(posedge clk) disable iff (rst)
    ram_we |-> $past(state) == S_RD)
    else $error("table write outside update step");

  // The pick scan never runs past the last level.
  assert property (@(posedge clk) disable iff (rst)
    state == S_EV && op_q == mfq_pkg::OP_PICK |-> lv <= LAST_LV)
    else $error("pick level out of range");

endmodule
`default_nettype wire
